### hw/rtl/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg
// Shared codes and field widths for the indexed sequence store.
// ----------------------------------------------------------------------------
package isq_pkg;

    // Field widths of the command and result words
    localparam int MODE_W   = 4;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_REPLACE    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_READ       = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

endpackage

### hw/rtl/isq_mem.sv
// ----------------------------------------------------------------------------
// isq_mem
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [isq_pkg::WORD_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [isq_pkg::WORD_W-1:0]  o_rdata
);
    import isq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // Write the entry and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered sequence of signed words with push, pop, insert, remove, replace,
// read and clear, kept in a single-port-write synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_mode, i_position and i_word_in and raise start; the command word
//   is taken at the edge where start is high and busy is low. busy stays
//   high while the command runs.
//   Each command gives one result word: o_word_out, o_length, o_status,
//   marked by o_valid for exactly one cycle. The receiver cannot stall it.
//   Errors, clear and unknown codes post the result straight from idle;
//   read and replace first fetch the entry at the index, and replace
//   writes the new word over it; push and insert shift the entries behind
//   the index up one place, then write the new word; pop and remove fetch
//   the entry, then shift the entries behind it down one place. Entries
//   are shifted one per cycle through the memory read/write ports, which
//   sets how long a command runs. A new command may be started in the cycle
//   o_valid is shown. Reset empties the sequence; the memory itself is not
//   cleared.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [isq_pkg::MODE_W-1:0]    i_mode,
    input  logic [isq_pkg::POS_W-1:0]     i_position,
    input  logic [isq_pkg::WORD_W-1:0]    i_word_in,
    output logic                          o_valid,
    output logic [isq_pkg::WORD_W-1:0]    o_word_out,
    output logic [isq_pkg::LEN_W-1:0]     o_length,
    output logic [isq_pkg::STATUS_W-1:0]  o_status
);
    import isq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_MOVE} t_state;
    typedef enum logic [1:0] {K_INSERT, K_REMOVE, K_REPLACE, K_READ} t_kind;

    t_state             r_state;
    t_kind              r_kind;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_pos;
    logic [WORD_W-1:0]  r_word;
    logic [AW-1:0]      r_src;
    logic [AW-1:0]      r_wdst;
    logic [CW-1:0]      r_cnt;
    logic               r_wpend;
    logic               r_down;
    logic               r_valid;
    logic [WORD_W-1:0]  r_word_out;
    logic [STATUS_W-1:0] r_status;

    logic               accept;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic               full;
    logic               empty;
    logic [AW-1:0]      n_pos;
    logic [STATUS_W-1:0] n_status;
    logic               is_ins;
    logic               is_rem;
    t_kind              n_kind;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [WORD_W-1:0]  mem_rdata;
    logic [XW-1:0]      len_x;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign pos_x  = XW'(i_position);
    assign cnt_x  = XW'(r_count);
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);

    // Decode the command: class, effective index and status
    always_comb begin
        is_ins   = 1'b0;
        is_rem   = 1'b0;
        n_kind   = K_READ;
        n_pos    = pos_x[AW-1:0];
        n_status = ST_OK;
        unique case (i_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
                is_ins = 1'b1;
                n_kind = K_INSERT;
                if (i_mode == MODE_PUSH_FRONT) begin
                    n_pos = '0;
                end else if (i_mode == MODE_PUSH_BACK) begin
                    n_pos = r_count[AW-1:0];
                end
                if (full) begin
                    n_status = ST_FULL;
                end else if (i_mode == MODE_INSERT && pos_x > cnt_x) begin
                    n_status = ST_INDEX;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE, MODE_REPLACE,
            MODE_READ: begin
                is_rem = 1'b1;
                if (i_mode == MODE_REPLACE) begin
                    n_kind = K_REPLACE;
                end else if (i_mode == MODE_READ) begin
                    n_kind = K_READ;
                end else begin
                    n_kind = K_REMOVE;
                end
                if (i_mode == MODE_POP_FRONT) begin
                    n_pos = '0;
                end else if (i_mode == MODE_POP_BACK) begin
                    n_pos = AW'(r_count - CW'(1));
                end
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if ((i_mode == MODE_REMOVE || i_mode == MODE_REPLACE ||
                              i_mode == MODE_READ) && pos_x >= cnt_x) begin
                    n_status = ST_INDEX;
                end
            end
            default: begin
            end
        endcase
    end

    // Memory port selection
    always_comb begin
        mem_raddr = r_src;
        mem_we    = 1'b0;
        mem_waddr = r_wdst;
        mem_wdata = mem_rdata;
        if (accept) begin
            mem_raddr = n_pos;
        end
        if (r_state == S_FETCH && r_kind == K_REPLACE) begin
            mem_we    = 1'b1;
            mem_waddr = r_pos;
            mem_wdata = r_word;
        end else if (r_state == S_MOVE && r_wpend) begin
            mem_we = 1'b1;
        end else if (r_state == S_MOVE && r_cnt == '0 && r_kind == K_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = r_pos;
            mem_wdata = r_word;
        end
    end

    isq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer: fetch where needed, shift entries one per cycle, then post the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_wpend <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind     <= n_kind;
                        r_pos      <= n_pos;
                        r_word     <= i_word_in;
                        r_word_out <= '0;
                        r_status   <= n_status;
                        r_wpend    <= 1'b0;
                        if (n_status != ST_OK || !(is_ins || is_rem)) begin
                            r_valid <= 1'b1;
                            if (i_mode == MODE_CLEAR) begin
                                r_count <= '0;
                            end
                        end else if (is_ins) begin
                            r_state <= S_MOVE;
                            r_down  <= 1'b1;
                            r_cnt   <= r_count - CW'(n_pos);
                            r_src   <= AW'(r_count - CW'(1));
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_word_out <= mem_rdata;
                    if (r_kind == K_REMOVE) begin
                        r_state <= S_MOVE;
                        r_down  <= 1'b0;
                        r_cnt   <= r_count - CW'(1) - CW'(r_pos);
                        r_src   <= r_pos + AW'(1);
                    end else begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                S_MOVE: begin
                    if (r_cnt != '0) begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_wpend <= 1'b1;
                        r_wdst  <= r_down ? r_src + AW'(1) : r_src - AW'(1);
                        r_src   <= r_down ? r_src - AW'(1) : r_src + AW'(1);
                    end else if (r_wpend) begin
                        r_wpend <= 1'b0;
                    end else begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                        if (r_kind == K_INSERT) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign len_x      = XW'(r_count);
    assign o_valid    = r_valid;
    assign o_word_out = r_word_out;
    assign o_length   = len_x[LEN_W-1:0];
    assign o_status   = r_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_word_out == '0))
        else $error("nonzero word on error result");
    a_wpend_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> (r_state == S_MOVE))
        else $error("shift write pending outside move");
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !o_valid) |=> (busy || o_valid))
        else $error("command ended without a result");
`endif

endmodule
